@@ src/rhhs_pkg.sv @@
package rhhs_pkg;

    // fixed field widths of the stream channels
    localparam int KEY_IN_W    = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // parameter defaults
    localparam int TABLE_SIZE_DEF = 8;
    localparam int KEY_WIDTH_DEF  = 32;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_MEMBER = 2'd1;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HOME,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

endpackage

@@ src/robin_hood_hash_set.sv @@
// robin hood hash set with linear probing
//
// input stream s_axis_*: one request per item, tdata carries the operation
// (insert, membership test, remove) and the key. output stream m_axis_*:
// exactly one result per request, tdata carries found and status.
//
// each request walks through a small sequencer: the quotient key / TABLE_SIZE
// comes from one reciprocal multiply, the home slot from a multiply-back and
// subtract, then the table memory is probed one slot at a time (read, then
// compare/swap/write through the shared compare unit), up to TABLE_SIZE probes.
// the result then passes to the output register, and only after that does the
// block go idle and take the next request; zero keys and the unused operation
// code skip the probes and go straight to the result. tready is high only
// while idle.
//
// the result sits in an output register: a new request is accepted while a
// result still waits, and the sequencer only holds at its last step when the
// receiver stalls with the output register still full.
//
// after reset a clearing pass writes every slot empty, and during it no
// request is accepted.
module robin_hood_hash_set #(
    parameter int TABLE_SIZE = rhhs_pkg::TABLE_SIZE_DEF,
    parameter int KEY_WIDTH  = rhhs_pkg::KEY_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request: [1:0] func, [33:2] key, [39:34] zero
    input  logic [rhhs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // result: [0] found, [2:1] status, [7:3] zero
    output logic [rhhs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);
    import rhhs_pkg::*;

    // slot index width and distance counter width
    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int DIST_W = $clog2(TABLE_SIZE + 1);
    // key bits that actually reach the table
    localparam int EFF_W  = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
    // each entry holds the key and its home slot
    localparam int ENT_W  = KEY_WIDTH + IDX_W;

    // key / size = (key * RECIP) >> MOD_SH, exact for every EFF_W-bit key
    localparam int          MOD_SH     = EFF_W + IDX_W;
    localparam int          PROD_W     = 2 * EFF_W + 1;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << MOD_SH) + 64'(TABLE_SIZE) - 64'd1)
                                         / 64'(TABLE_SIZE);
    localparam logic [EFF_W:0] RECIP   = RECIP_FULL[EFF_W:0];

    localparam logic [IDX_W:0]   SIZE_EXT = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    // input field split
    logic [FUNC_W-1:0]   in_func;
    logic [KEY_IN_W-1:0] in_key;
    logic [KEY_WIDTH-1:0] in_key_eff;

    assign in_func    = s_axis_tdata[FUNC_W-1:0];
    assign in_key     = s_axis_tdata[FUNC_W+KEY_IN_W-1:FUNC_W];
    assign in_key_eff = KEY_WIDTH'(in_key[EFF_W-1:0]);

    // table memory, registered read
    logic [ENT_W-1:0] tbl_mem [TABLE_SIZE];
    logic [ENT_W-1:0] rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    // sequencer state
    state_t state_reg, state_next;

    logic [FUNC_W-1:0]    op_reg, op_next;
    logic [KEY_WIDTH-1:0] car_key_reg, car_key_next;     // key being carried
    logic [IDX_W-1:0]     car_home_reg, car_home_next;   // its home slot
    logic [EFF_W-1:0]     quo_reg, quo_next;             // key / table size
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     n_reg, n_next;                 // probes done
    logic [DIST_W-1:0]    dist_reg, dist_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                 res_found_reg, res_found_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    // shared datapath
    logic [EFF_W-1:0]     key_lo;
    logic [PROD_W-1:0]    mod_prod;
    logic [IDX_W-1:0]     home_calc;
    logic [KEY_WIDTH-1:0] res_key;
    logic [IDX_W-1:0]     res_home;
    logic [IDX_W-1:0]     res_dist;
    logic [IDX_W-1:0]     pos_inc;
    logic                 last_probe;
    logic                 key_hit;
    logic                 key_empty;
    logic                 swap;

    // home slot: reciprocal multiply, then remainder = key - quotient * size
    assign key_lo    = car_key_reg[EFF_W-1:0];
    assign mod_prod  = PROD_W'(key_lo) * PROD_W'(RECIP);
    assign home_calc = IDX_W'(key_lo - EFF_W'(quo_reg * TABLE_SIZE));

    assign res_key  = rd_data_reg[KEY_WIDTH-1:0];
    assign res_home = rd_data_reg[ENT_W-1:KEY_WIDTH];

    // resident's distance from its home, wrapping round the table
    assign res_dist = (pos_reg >= res_home)
                    ? IDX_W'(pos_reg - res_home)
                    : IDX_W'(({1'b0, pos_reg} + SIZE_EXT) - {1'b0, res_home});

    assign pos_inc    = (pos_reg == LAST_IDX) ? '0 : IDX_W'(pos_reg + 1'b1);
    assign last_probe = (n_reg == LAST_IDX);
    assign key_hit    = (res_key == car_key_reg);
    assign key_empty  = (res_key == '0);
    assign swap       = (DIST_W'(res_dist) < dist_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= tbl_mem[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= OP_INSERT;
            car_key_reg    <= '0;
            car_home_reg   <= '0;
            quo_reg        <= '0;
            pos_reg        <= '0;
            n_reg          <= '0;
            dist_reg       <= '0;
            clr_cnt_reg    <= '0;
            res_found_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            op_reg         <= op_next;
            car_key_reg    <= car_key_next;
            car_home_reg   <= car_home_next;
            quo_reg        <= quo_next;
            pos_reg        <= pos_next;
            n_reg          <= n_next;
            dist_reg       <= dist_next;
            clr_cnt_reg    <= clr_cnt_next;
            res_found_reg  <= res_found_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_found_reg  <= out_found_next;
            out_status_reg <= out_status_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        car_key_next    = car_key_reg;
        car_home_next   = car_home_reg;
        quo_next        = quo_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        dist_next       = dist_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = {car_home_reg, car_key_reg};
        s_axis_tready   = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // empty every slot after reset
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = IDX_W'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next         = in_func;
                    car_key_next    = in_key_eff;
                    res_found_next  = 1'b0;
                    res_status_next = ST_OK;
                    priority if (in_func != OP_INSERT && in_func != OP_MEMBER
                                 && in_func != OP_REMOVE)
                    begin
                        // unused operation: table untouched
                        state_next = S_DONE;
                    end
                    else if (in_key_eff == '0)
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MOD;
                    end
                end
            end

            S_MOD:
            begin
                // quotient of key by table size
                quo_next   = EFF_W'(mod_prod >> MOD_SH);
                state_next = S_HOME;
            end

            S_HOME:
            begin
                // home slot = key mod table size
                pos_next      = home_calc;
                car_home_next = home_calc;
                n_next        = '0;
                dist_next     = '0;
                state_next    = S_READ;
            end

            S_READ:
            begin
                // slot at pos_reg is read into rd_data_reg at this edge
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                pos_next   = pos_inc;
                n_next     = IDX_W'(n_reg + 1'b1);
                state_next = S_READ;
                if (op_reg == OP_INSERT)
                begin
                    priority if (key_hit)
                    begin
                        res_found_next = 1'b1;
                        state_next     = S_DONE;
                    end
                    else if (key_empty)
                    begin
                        wr_en      = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        if (swap)
                        begin
                            // resident is richer: take its place, carry it on
                            wr_en         = 1'b1;
                            car_key_next  = res_key;
                            car_home_next = res_home;
                            dist_next     = DIST_W'(res_dist) + 1'b1;
                        end
                        else
                        begin
                            dist_next = DIST_W'(dist_reg + 1'b1);
                        end
                        if (last_probe)
                        begin
                            // no free slot, carried key is dropped
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                    end
                end
                else
                begin
                    // membership test or remove
                    if (key_hit)
                    begin
                        res_found_next = 1'b1;
                        state_next     = S_DONE;
                        if (op_reg == OP_REMOVE)
                        begin
                            wr_en   = 1'b1;
                            wr_data = '0;
                        end
                    end
                    else if (last_probe)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - STATUS_W - 1){1'b0}}, out_status_reg, out_found_reg};

endmodule

@@ dv/robin_hood_hash_set_test.sv @@
`timescale 1ns / 100ps

module robin_hood_hash_set_test;

    import rhhs_pkg::*;

    // table geometry of the default build
    localparam int SLOTS  = TABLE_SIZE_DEF;
    localparam int HOME_W = $clog2(SLOTS);

    // the spare operation code, accepted but leaving the table alone
    localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

    // size of the key pool that random requests mostly draw from
    localparam int POOL_SIZE = 11;

    // requests per phase of random traffic
    localparam int PHASE_REQUESTS = 340;

    // cycles without any handshake before the run is abandoned
    localparam int STALL_LIMIT = 3000;

    // settling time after the last result, well over the longest request
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [FUNC_W-1:0]   op;
        logic [KEY_IN_W-1:0] key;
    } hash_request_t;

    typedef struct {
        logic                found;
        logic [STATUS_W-1:0] status;
    } hash_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    // requests waiting to be driven, and results owed by the block
    hash_request_t request_queue[$];
    hash_result_t  awaited_results[$];

    // shadow copy of the slot store, empty after reset
    logic [KEY_IN_W-1:0] shadow_slots [SLOTS] = '{default: '0};

    logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];
    logic [FUNC_W-1:0]   valid_ops [3] = '{OP_INSERT, OP_MEMBER, OP_REMOVE};

    // idling percentages of the current phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    logic req_taken = 1'b0;
    int   idle_cycles = 0;
    int   mismatch_count = 0;

    always #6 clk = ~clk;

    robin_hood_hash_set dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // applies one request to the shadow store and returns the result it owes
    function automatic hash_result_t apply_to_shadow(input hash_request_t req);
        hash_result_t        res;
        logic [HOME_W-1:0]   pos;
        logic [HOME_W-1:0]   resident_dist;
        logic [KEY_IN_W-1:0] carried;
        logic [KEY_IN_W-1:0] evicted;
        int                  carried_dist;
        bit                  done;
        res.found = 1'b0;
        res.status = ST_OK;
        done = 1'b0;
        // the spare code produces a plain ok result
        if (req.op == OP_UNUSED)
            return res;
        // zero is the empty mark, so it is refused for insert, membership and remove
        if (req.key == '0)
        begin
            res.status = ST_ZERO;
            return res;
        end
        if (req.op == OP_INSERT)
        begin
            carried = req.key;
            pos = carried[HOME_W-1:0];
            carried_dist = 0;
            for (int n = 0; n < SLOTS && !done; n++)
            begin
                if (shadow_slots[pos] == carried)
                begin
                    // also hits when the carried key is one displaced earlier
                    res.found = 1'b1;
                    done = 1'b1;
                end
                else if (shadow_slots[pos] == '0)
                begin
                    shadow_slots[pos] = carried;
                    done = 1'b1;
                end
                else
                begin
                    // wrap-round distance of the resident from its home slot
                    resident_dist = pos - shadow_slots[pos][HOME_W-1:0];
                    if (int'(resident_dist) < carried_dist)
                    begin
                        // richer resident gives way, carry it on instead
                        carried_dist = int'(resident_dist);
                        evicted = shadow_slots[pos];
                        shadow_slots[pos] = carried;
                        carried = evicted;
                    end
                    carried_dist++;
                    pos++;
                end
            end
            // no empty slot anywhere: whatever is carried now is lost
            if (!done)
                res.status = ST_FULL;
        end
        else
        begin
            // membership and remove look at every slot from home round
            pos = req.key[HOME_W-1:0];
            for (int n = 0; n < SLOTS; n++)
            begin
                if (!done && shadow_slots[pos] == req.key)
                begin
                    if (req.op == OP_REMOVE)
                        shadow_slots[pos] = '0;
                    res.found = 1'b1;
                    done = 1'b1;
                end
                pos++;
            end
        end
        return res;
    endfunction

    // random traffic, mostly on a small pool of keys so that the table fills,
    // keys collide on home slots and removes find what inserts put there
    task automatic queue_random_requests(input int count);
        hash_request_t req;
        int            pick;
        int            weight;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                for (int j = 0; j < POOL_SIZE; j++)
                begin
                    key_pool[j] = $urandom;
                    // crowd about half the pool onto home slots 0 to 2
                    if ($urandom_range(0, 1))
                        key_pool[j][HOME_W-1:0] = HOME_W'($urandom_range(0, 2));
                    if (key_pool[j] == '0)
                        key_pool[j] = 1;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                req.op = valid_ops[$urandom_range(0, 2)];
                req.key = '0;
            end
            else if (pick < 6)
            begin
                req.op = OP_UNUSED;
                req.key = $urandom;
            end
            else if (pick < 12)
            begin
                req.op = valid_ops[$urandom_range(0, 2)];
                req.key = $urandom;
            end
            else
            begin
                req.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                weight = $urandom_range(0, 99);
                if (weight < 45)
                    req.op = OP_INSERT;
                else if (weight < 75)
                    req.op = OP_MEMBER;
                else
                    req.op = OP_REMOVE;
            end
            request_queue.push_back(req);
        end
    endtask

    // opening requests: zero keys, the spare code, extreme keys, a pile-up on
    // one home slot, a full table, lookups of absent keys and removes
    task automatic queue_directed_requests();
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h0000_0000});
        request_queue.push_back(hash_request_t'{OP_MEMBER, 32'h0000_0000});
        request_queue.push_back(hash_request_t'{OP_REMOVE, 32'h0000_0000});
        request_queue.push_back(hash_request_t'{OP_UNUSED, 32'h0000_0005});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'hFFFF_FFFF});
        request_queue.push_back(hash_request_t'{OP_MEMBER, 32'hFFFF_FFFF});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'hFFFF_FFFF});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h0000_0008});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h0000_0010});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h0000_0018});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h0000_0001});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h8000_0000});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h0000_0002});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h0000_0003});
        // the table is now full
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h0000_0017});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h0000_0010});
        request_queue.push_back(hash_request_t'{OP_MEMBER, 32'h0000_0005});
        request_queue.push_back(hash_request_t'{OP_REMOVE, 32'h0000_0018});
        request_queue.push_back(hash_request_t'{OP_REMOVE, 32'h0000_0018});
        request_queue.push_back(hash_request_t'{OP_MEMBER, 32'h8000_0000});
        request_queue.push_back(hash_request_t'{OP_UNUSED, 32'h0000_0000});
        request_queue.push_back(hash_request_t'{OP_REMOVE, 32'hFFFF_FFFF});
        request_queue.push_back(hash_request_t'{OP_INSERT, 32'h7FFF_FFF8});
    endtask

    // request driver and result back-pressure, both moved on the falling edge
    always @(negedge clk)
    begin : request_driver
        hash_request_t next_req;
        if (!s_axis_tvalid || req_taken)
        begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_req = request_queue.pop_front();
                // request: [1:0] func, [33:2] key, [39:34] zero
                s_axis_tdata <= {6'b0, next_req.key, next_req.op};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // predictor on accepted requests, result checker and watchdog
    always @(posedge clk)
    begin : result_monitor
        hash_request_t taken_req;
        hash_result_t  owed;
        logic          got_found;
        logic [1:0]    got_status;
        req_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
        begin
            taken_req.op = s_axis_tdata[1:0];
            taken_req.key = s_axis_tdata[33:2];
            awaited_results.push_back(apply_to_shadow(taken_req));
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            // result: [0] found, [2:1] status
            got_found = m_axis_tdata[0];
            got_status = m_axis_tdata[2:1];
            if (awaited_results.size() == 0)
            begin
                $error("result with no request awaiting it: tdata %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                owed = awaited_results.pop_front();
                if (got_found !== owed.found)
                begin
                    $error("found mismatch: expected %0d, got %0d", owed.found, got_found);
                    mismatch_count++;
                end
                if (got_status !== owed.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", owed.status,
                           got_status);
                    mismatch_count++;
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // reset, then four phases of traffic with different idling on each side
    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (phase == 0)
                queue_directed_requests();
            queue_random_requests(PHASE_REQUESTS);
            // let every request go in and every result come back
            while (request_queue.size() != 0 || s_axis_tvalid ||
                   awaited_results.size() != 0)
                @(negedge clk);
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/rhhs_pkg.sv
src/robin_hood_hash_set.sv
dv/robin_hood_hash_set_test.sv
